// ----- hw/rtl/bbc_pkg.sv -----
// shared types and constants of the buffer cache tag controller
package bbc_pkg;

	localparam int SLOTS = 32;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int DEV_W = 8;
	localparam int BLK_W = 24;
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

	// request codes
	typedef enum logic [1:0] {
		ACT_GET     = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_DIRTY   = 2'd2,
		ACT_CLEAN   = 2'd3
	} act_t;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_FREE  = 2'd1;
	localparam logic [1:0] STAT_NOT_HELD = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_PICK,
		S_UPD
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic compare;
		logic pick;
		logic update;
	} cmd_t;

endpackage

// ----- hw/rtl/bbc_ctrl.sv -----
// controller state machine: sequences one request through compare, pick and update
module bbc_ctrl
	import bbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	// state and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				// commit only when the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.update = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/bbc_datapath.sv -----
// datapath: slot tags, use counts, flags, recency ranks and the result register
module bbc_datapath
	import bbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [1:0]       action,
	input  logic [DEV_W-1:0] device,
	input  logic [BLK_W-1:0] block_number,
	input  logic [4:0]       slot_in,
	output logic [4:0]       slot_out,
	output logic             hit,
	output logic             needs_read,
	output logic [1:0]       status
);

	// per-slot state; rank is the slot's place in recency order, 0 most recent
	logic [DEV_W-1:0]  tag_dev_q [SLOTS];
	logic [BLK_W-1:0]  tag_blk_q [SLOTS];
	logic [CNT_W-1:0]  use_q     [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	logic [SLOTS-1:0]  dirty_q;
	logic [SLOT_W-1:0] rank_q    [SLOTS];

	// captured request
	act_t             act_q;
	logic [DEV_W-1:0] dev_q;
	logic [BLK_W-1:0] blk_q;
	logic [4:0]       slot_q;

	// pipeline of the search
	logic [SLOTS-1:0]  match_s1;
	logic [SLOTS-1:0]  cand_s1;
	logic              found_s2;
	logic              hit_s2;
	logic [SLOT_W-1:0] pos_s2;

	// result register
	logic [4:0] slot_out_q;
	logic       hit_q;
	logic       needs_read_q;
	logic [1:0] status_q;

	// pick logic signals
	logic [SLOTS-1:0]  pos_match;
	logic [SLOTS-1:0]  pos_cand;
	logic              any_match;
	logic              any_cand;
	logic [SLOT_W-1:0] match_pos;
	logic [SLOT_W-1:0] cand_pos;

	// update logic signals
	logic [SLOTS-1:0]  sel_g;
	logic [SLOTS-1:0]  sel_in;
	logic [SLOT_W-1:0] g_slot;
	logic              g_valid;
	logic [CNT_W-1:0]  in_use;
	logic [SLOT_W-1:0] in_rank;
	logic              in_range;
	logic              held;
	logic              rel_zero;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= act_t'(action);
			dev_q <= device;
			blk_q <= block_number;
			slot_q <= slot_in;
		end
	end

	// map slot vectors onto recency positions and pick the ends
	always_comb begin
		pos_match = '0;
		pos_cand = '0;
		for (int p = 0; p < SLOTS; p++) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (rank_q[s] == SLOT_W'(p)) begin
					pos_match[p] = pos_match[p] | match_s1[s];
					pos_cand[p] = pos_cand[p] | cand_s1[s];
				end
			end
		end
		any_match = |pos_match;
		any_cand = |pos_cand;
		// most recent match: lowest position wins
		match_pos = '0;
		for (int p = SLOTS - 1; p >= 0; p--) begin
			if (pos_match[p]) begin
				match_pos = SLOT_W'(p);
			end
		end
		// least recent free clean slot: highest position wins
		cand_pos = '0;
		for (int p = 0; p < SLOTS; p++) begin
			if (pos_cand[p]) begin
				cand_pos = SLOT_W'(p);
			end
		end
	end

	// compare and pick stages
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int s = 0; s < SLOTS; s++) begin
				match_s1[s] <= (tag_dev_q[s] == dev_q) && (tag_blk_q[s] == blk_q);
				cand_s1[s] <= (use_q[s] == '0) && !dirty_q[s];
			end
		end
		if (cmd.pick) begin
			hit_s2 <= any_match;
			found_s2 <= any_match || any_cand;
			pos_s2 <= any_match ? match_pos : cand_pos;
		end
	end

	// selection of the granted slot and the addressed slot
	always_comb begin
		g_slot = '0;
		g_valid = 1'b0;
		in_use = '0;
		in_rank = '0;
		for (int s = 0; s < SLOTS; s++) begin
			sel_g[s] = (rank_q[s] == pos_s2);
			sel_in[s] = (slot_q == 5'(s));
			if (sel_g[s]) begin
				g_slot = g_slot | SLOT_W'(s);
				g_valid = g_valid | valid_q[s];
			end
			if (sel_in[s]) begin
				in_use = in_use | use_q[s];
				in_rank = in_rank | rank_q[s];
			end
		end
		in_range = |sel_in;
		held = (in_use != '0);
		rel_zero = (act_q == ACT_RELEASE) && held && (in_use == CNT_W'(1));
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				tag_dev_q[s] <= '0;
				tag_blk_q[s] <= '0;
				use_q[s] <= '0;
				rank_q[s] <= SLOT_W'(SLOTS - 1 - s);
			end
			valid_q <= '0;
			dirty_q <= '0;
		end else if (cmd.update) begin
			for (int s = 0; s < SLOTS; s++) begin
				case (act_q)
					ACT_GET: begin
						if (found_s2 && sel_g[s]) begin
							valid_q[s] <= 1'b1;
							if (hit_s2) begin
								if (use_q[s] != COUNT_MAX) begin
									use_q[s] <= use_q[s] + CNT_W'(1);
								end
							end else begin
								tag_dev_q[s] <= dev_q;
								tag_blk_q[s] <= blk_q;
								use_q[s] <= CNT_W'(1);
								dirty_q[s] <= 1'b0;
							end
						end
					end
					ACT_RELEASE: begin
						if (held && sel_in[s]) begin
							use_q[s] <= use_q[s] - CNT_W'(1);
						end
						// move to the most recent end when the count drops to zero
						if (rel_zero) begin
							if (sel_in[s]) begin
								rank_q[s] <= '0;
							end else if (rank_q[s] < in_rank) begin
								rank_q[s] <= rank_q[s] + SLOT_W'(1);
							end
						end
					end
					ACT_DIRTY: begin
						if (held && sel_in[s]) begin
							dirty_q[s] <= 1'b1;
						end
					end
					default: begin
						if (sel_in[s]) begin
							dirty_q[s] <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q <= 1'b0;
			needs_read_q <= 1'b0;
			slot_out_q <= slot_q;
			case (act_q)
				ACT_GET: begin
					if (found_s2) begin
						slot_out_q <= 5'(g_slot);
						hit_q <= hit_s2;
						needs_read_q <= hit_s2 ? !g_valid : 1'b1;
						status_q <= STAT_OK;
					end else begin
						slot_out_q <= '0;
						status_q <= STAT_NO_FREE;
					end
				end
				ACT_RELEASE, ACT_DIRTY: begin
					status_q <= held ? STAT_OK : STAT_NOT_HELD;
				end
				default: begin
					status_q <= in_range ? STAT_OK : STAT_NOT_HELD;
				end
			endcase
		end
	end

	assign slot_out = slot_out_q;
	assign hit = hit_q;
	assign needs_read = needs_read_q;
	assign status = status_q;

endmodule

// ----- hw/rtl/block_buffer_cache_lru_core.sv -----
// top level of the lru block buffer cache tag controller
// Each request (get, release, mark dirty, mark clean) passes from acceptance
// to result through capture, a parallel tag and free-slot compare over all
// 32 slots, a pick of the most recent match or least recent free clean slot
// through the recency ranks, and the state update that loads the result
// register. The controller works on one request at a time and is ready again
// the cycle after the update, even while the last result still waits to be
// taken; if the previous result is still held, the update waits for it.
// Recency is a rank per slot; a release that drops a count to zero reorders the
// more recent slots in the update cycle. No clearing pass is needed after reset.
module block_buffer_cache_lru_core
	import bbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  device,
	input  logic [23:0] block_number,
	input  logic [4:0]  slot_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  slot_out,
	output logic        hit,
	output logic        needs_read,
	output logic [1:0]  status
);

	cmd_t cmd;

	// request sequencing
	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// slot state and result
	bbc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.device       (device),
		.block_number (block_number),
		.slot_in      (slot_in),
		.slot_out     (slot_out),
		.hit          (hit),
		.needs_read   (needs_read),
		.status       (status)
	);

endmodule
